// ===== design/lbc_pkg.sv =====
package lbc_pkg;

  localparam int ENTRIES    = 16;
  localparam int BLOCK_BITS = 12;
  localparam int STAMP_BITS = 32;
  localparam int CMD_BITS   = 3;
  localparam int SLOT_BITS  = $clog2(ENTRIES);
  localparam int CNT_BITS   = $clog2(ENTRIES + 1);

  localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_FILL   = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_UPDATE = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_FLUSH  = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [2:0] EMIT_NONE   = 3'd0;
  localparam logic [2:0] EMIT_ZERO   = 3'd1;
  localparam logic [2:0] EMIT_HIT    = 3'd2;
  localparam logic [2:0] EMIT_INSERT = 3'd3;
  localparam logic [2:0] EMIT_EVICT  = 3'd4;
  localparam logic [2:0] EMIT_FLUSH  = 3'd5;

  typedef struct packed {
    logic       load;
    logic       scan_clr;
    logic       scan_inc;
    logic       vict_step;
    logic       hit_save;
    logic       clear;
    logic [2:0] emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    logic                scan_end;
    logic                match;
    logic                full;
    logic                out_free;
    logic                cand_dirty;
    logic                rem_zero;
    logic                dirty_none;
  } ctl_sts_t;

endpackage

// ===== design/lbc_req_if.sv =====
interface lbc_req_if;
  import lbc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CMD_BITS-1:0]   command;
  logic [BLOCK_BITS-1:0] block_number;
  logic [STAMP_BITS-1:0] now_tick;

  modport source (output valid, command, block_number, now_tick, input ready);
  modport sink (input valid, command, block_number, now_tick, output ready);
endinterface

// ===== design/lbc_rsp_if.sv =====
interface lbc_rsp_if;
  import lbc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [SLOT_BITS-1:0]  slot;
  logic                  evicted;
  logic [BLOCK_BITS-1:0] evicted_block;
  logic                  evicted_dirty;
  logic                  flush_valid;
  logic [BLOCK_BITS-1:0] flush_block;
  logic                  last;

  modport source (output valid, hit, slot, evicted, evicted_block, evicted_dirty,
                  flush_valid, flush_block, last, input ready);
  modport sink (input valid, hit, slot, evicted, evicted_block, evicted_dirty,
                flush_valid, flush_block, last, output ready);
endinterface

// ===== design/lru_block_cache_tags_unit.sv =====
// Tag and replacement side of a fully associative block cache.
// req channel: one transaction carries command, block_number and now_tick;
// it is taken only while the unit is idle. rsp channel: hit, slot, eviction
// report, flush report and last; slot addresses the external data store.
// Read, fill, write, clear and unknown commands give one response. Flush
// gives one response per dirty entry in insertion order, or a single one
// if none is dirty, then clears. Lookups walk the live entries in
// insertion order, one entry per cycle. A fill into a full cache adds a
// second walk over all entries for the oldest stamp. A flush walks the
// entries up to the last dirty one, waiting at each dirty entry while the
// receiver stalls, then clears. The next request is taken only once the
// last response is loaded, and after a flush that listed blocks only once
// the clear is done, so the unit takes no new request before it is
// through with the last one. Reset clears the valid and dirty bits, the
// fill count and the dirty count at once; there is no clearing pass. When
// the receiver stalls, the response is held in the output register and
// the walk waits before issuing the next.
module lru_block_cache_tags_unit (
  input logic       clk,
  input logic       rst,
  lbc_req_if.sink   req,
  lbc_rsp_if.source rsp
);
  import lbc_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  lbc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.command),
    .in_ready   (req.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lbc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_command    (req.command),
    .in_block      (req.block_number),
    .in_tick       (req.now_tick),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .hit           (rsp.hit),
    .slot          (rsp.slot),
    .evicted       (rsp.evicted),
    .evicted_block (rsp.evicted_block),
    .evicted_dirty (rsp.evicted_dirty),
    .flush_valid   (rsp.flush_valid),
    .flush_block   (rsp.flush_block),
    .last          (rsp.last)
  );

endmodule

// ===== design/lbc_ctrl.sv =====
module lbc_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [lbc_pkg::CMD_BITS-1:0] in_command,
  output logic                         in_ready,
  input  lbc_pkg::ctl_sts_t            sts,
  output lbc_pkg::ctl_cmd_t            cmd
);
  import lbc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOOK   = 4'd1;
  localparam logic [3:0] S_HIT    = 4'd2;
  localparam logic [3:0] S_MISS   = 4'd3;
  localparam logic [3:0] S_INSERT = 4'd4;
  localparam logic [3:0] S_VICT   = 4'd5;
  localparam logic [3:0] S_EVICT  = 4'd6;
  localparam logic [3:0] S_FLUSH  = 4'd7;
  localparam logic [3:0] S_MISC   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.emit = EMIT_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_command == CMD_LOOKUP || in_command == CMD_FILL ||
              in_command == CMD_UPDATE) begin
            state_next = S_LOOK;
          end else if (in_command == CMD_FLUSH) begin
            state_next = S_FLUSH;
          end else begin
            state_next = S_MISC;
          end
        end
      end
      S_LOOK: begin
        if (sts.scan_end) begin
          if (sts.cmd != CMD_FILL) begin
            state_next = S_MISS;
          end else if (sts.full) begin
            cmd.scan_clr = 1'b1;
            state_next = S_VICT;
          end else begin
            state_next = S_INSERT;
          end
        end else if (sts.match) begin
          cmd.hit_save = 1'b1;
          state_next = S_HIT;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_HIT: begin
        if (sts.out_free) begin
          cmd.emit = EMIT_HIT;
          state_next = S_IDLE;
        end
      end
      S_MISS: begin
        if (sts.out_free) begin
          cmd.emit = EMIT_ZERO;
          state_next = S_IDLE;
        end
      end
      S_INSERT: begin
        if (sts.out_free) begin
          cmd.emit = EMIT_INSERT;
          state_next = S_IDLE;
        end
      end
      S_VICT: begin
        if (sts.scan_end) begin
          state_next = S_EVICT;
        end else begin
          cmd.vict_step = 1'b1;
        end
      end
      S_EVICT: begin
        if (sts.out_free) begin
          cmd.emit = EMIT_EVICT;
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (sts.rem_zero) begin
          // all dirty entries listed; an empty flush still owes one result
          if (!sts.dirty_none) begin
            cmd.clear = 1'b1;
            state_next = S_IDLE;
          end else if (sts.out_free) begin
            cmd.clear = 1'b1;
            cmd.emit = EMIT_ZERO;
            state_next = S_IDLE;
          end
        end else if (sts.cand_dirty) begin
          if (sts.out_free) begin
            cmd.emit = EMIT_FLUSH;
          end
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_MISC: begin
        if (sts.out_free) begin
          cmd.emit = EMIT_ZERO;
          cmd.clear = (sts.cmd == CMD_CLEAR);
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/lbc_datapath.sv =====
module lbc_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  lbc_pkg::ctl_cmd_t              cmd,
  output lbc_pkg::ctl_sts_t              sts,
  input  logic [lbc_pkg::CMD_BITS-1:0]   in_command,
  input  logic [lbc_pkg::BLOCK_BITS-1:0] in_block,
  input  logic [lbc_pkg::STAMP_BITS-1:0] in_tick,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit,
  output logic [lbc_pkg::SLOT_BITS-1:0]  slot,
  output logic                           evicted,
  output logic [lbc_pkg::BLOCK_BITS-1:0] evicted_block,
  output logic                           evicted_dirty,
  output logic                           flush_valid,
  output logic [lbc_pkg::BLOCK_BITS-1:0] flush_block,
  output logic                           last
);
  import lbc_pkg::*;

  function automatic logic [SLOT_BITS-1:0] lowest_free(input logic [ENTRIES-1:0] v);
    logic [ENTRIES-1:0]   f;
    logic [ENTRIES-1:0]   one;
    logic [SLOT_BITS-1:0] idx;
    f = ~v;
    one = f & (~f + ENTRIES'(1));
    idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (one[i]) idx = idx | SLOT_BITS'(i);
    end
    return idx;
  endfunction

  logic [ENTRIES-1:0]    entry_valid;
  logic [ENTRIES-1:0]    entry_dirty;
  logic [BLOCK_BITS-1:0] entry_block [ENTRIES];
  logic [STAMP_BITS-1:0] entry_stamp [ENTRIES];
  // rank_slot[r] is the slot inserted r-th; ranks below entry_count are live
  logic [SLOT_BITS-1:0]  rank_slot [ENTRIES];
  logic [CNT_BITS-1:0]   entry_count;
  logic [CNT_BITS-1:0]   dirty_count;

  logic [CNT_BITS-1:0]   scan;
  logic [CNT_BITS-1:0]   rem;
  logic [CMD_BITS-1:0]   cur_cmd;
  logic [BLOCK_BITS-1:0] cur_block;
  logic [STAMP_BITS-1:0] cur_tick;
  logic [SLOT_BITS-1:0]  hit_slot;
  logic [STAMP_BITS-1:0] best_stamp;
  logic [SLOT_BITS-1:0]  best_rank;
  logic [SLOT_BITS-1:0]  best_slot;
  logic [BLOCK_BITS-1:0] best_block;
  logic                  best_dirty;

  logic [SLOT_BITS-1:0]  cur_slot;
  logic [BLOCK_BITS-1:0] cur_entry_block;
  logic [STAMP_BITS-1:0] cur_entry_stamp;
  logic                  better;
  logic [SLOT_BITS-1:0]  free_slot;
  logic                  out_free;

  assign cur_slot        = rank_slot[scan[SLOT_BITS-1:0]];
  assign cur_entry_block = entry_block[cur_slot];
  assign cur_entry_stamp = entry_stamp[cur_slot];
  assign better          = (scan == '0) || (cur_entry_stamp < best_stamp);
  assign free_slot       = lowest_free(entry_valid);
  assign out_free        = !out_valid || out_ready;

  always_comb begin
    sts.cmd        = cur_cmd;
    sts.scan_end   = (scan == entry_count);
    sts.match      = (cur_entry_block == cur_block);
    sts.full       = (entry_count == CNT_BITS'(ENTRIES));
    sts.out_free   = out_free;
    sts.cand_dirty = entry_dirty[cur_slot];
    sts.rem_zero   = (rem == '0);
    sts.dirty_none = (dirty_count == '0);
  end

  // transaction registers and scan control
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_cmd   <= in_command;
      cur_block <= in_block;
      cur_tick  <= in_tick;
      rem       <= dirty_count;
    end
    if (cmd.load || cmd.scan_clr) begin
      scan <= '0;
    end else if (cmd.scan_inc || cmd.vict_step || cmd.emit == EMIT_FLUSH) begin
      scan <= scan + CNT_BITS'(1);
    end
    if (cmd.emit == EMIT_FLUSH) begin
      rem <= rem - CNT_BITS'(1);
    end
    if (cmd.hit_save) begin
      hit_slot <= cur_slot;
    end
    if (cmd.vict_step && better) begin
      best_stamp <= cur_entry_stamp;
      best_rank  <= scan[SLOT_BITS-1:0];
      best_slot  <= cur_slot;
      best_block <= cur_entry_block;
      best_dirty <= entry_dirty[cur_slot];
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    case (cmd.emit)
      EMIT_HIT: begin
        entry_stamp[hit_slot] <= cur_tick;
      end
      EMIT_INSERT: begin
        entry_block[free_slot] <= cur_block;
        entry_stamp[free_slot] <= cur_tick;
        rank_slot[entry_count[SLOT_BITS-1:0]] <= free_slot;
      end
      EMIT_EVICT: begin
        entry_block[best_slot] <= cur_block;
        entry_stamp[best_slot] <= cur_tick;
        // close the gap at the victim's rank and append it as newest
        for (int j = 0; j < ENTRIES - 1; j++) begin
          if (SLOT_BITS'(j) >= best_rank) begin
            rank_slot[j] <= rank_slot[j + 1];
          end
        end
        rank_slot[ENTRIES - 1] <= best_slot;
      end
      default: begin
      end
    endcase
  end

  // entry control state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      entry_valid <= '0;
      entry_dirty <= '0;
      entry_count <= '0;
      dirty_count <= '0;
    end else begin
      case (cmd.emit)
        EMIT_HIT: begin
          if (cur_cmd == CMD_UPDATE) begin
            entry_dirty[hit_slot] <= 1'b1;
            if (!entry_dirty[hit_slot]) begin
              dirty_count <= dirty_count + CNT_BITS'(1);
            end
          end
        end
        EMIT_INSERT: begin
          entry_valid[free_slot] <= 1'b1;
          entry_dirty[free_slot] <= 1'b0;
          entry_count <= entry_count + CNT_BITS'(1);
        end
        EMIT_EVICT: begin
          entry_dirty[best_slot] <= 1'b0;
          if (best_dirty) begin
            dirty_count <= dirty_count - CNT_BITS'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EMIT_NONE) begin
      hit           <= 1'b0;
      slot          <= '0;
      evicted       <= 1'b0;
      evicted_block <= '0;
      evicted_dirty <= 1'b0;
      flush_valid   <= 1'b0;
      flush_block   <= '0;
      last          <= 1'b1;
      case (cmd.emit)
        EMIT_HIT: begin
          hit  <= 1'b1;
          slot <= hit_slot;
        end
        EMIT_INSERT: begin
          slot <= free_slot;
        end
        EMIT_EVICT: begin
          slot          <= best_slot;
          evicted       <= 1'b1;
          evicted_block <= best_block;
          evicted_dirty <= best_dirty;
        end
        EMIT_FLUSH: begin
          slot        <= cur_slot;
          flush_valid <= 1'b1;
          flush_block <= cur_entry_block;
          last        <= (rem == CNT_BITS'(1));
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/lbc_checker.sv =====
module lbc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [lbc_pkg::SLOT_BITS-1:0]  rsp_slot,
  input logic [lbc_pkg::BLOCK_BITS-1:0] rsp_flush_block,
  input logic                           rsp_last
);
  import lbc_pkg::*;

  // one request at a time: busy right after a transaction
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while a previous one is in progress");

  // a non-final flush response means the flush is still running
  a_flush_busy: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_last) |-> !req_ready)
    else $error("request port open during a multi-response flush");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_slot) && $stable(rsp_flush_block) && $stable(rsp_last)))
    else $error("stalled response changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind lru_block_cache_tags_unit lbc_checker u_lbc_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_slot        (rsp.slot),
  .rsp_flush_block (rsp.flush_block),
  .rsp_last        (rsp.last)
);
